>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> design/llf_pkg.sv
// ---------------------------------------------------------------------------
// Least-laxity-first scheduler package
// Sizes, field widths and the records passed between the cell row and control.
// ---------------------------------------------------------------------------
package llf_pkg;

   // Table size and time width.
   localparam int MAX_TASKS = 8;
   localparam int TIME_BITS = 16;
   localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   // Laxity spans deadline minus two time values, so two extra bits hold it.
   localparam int LAX_W     = TIME_BITS + 2;

   // Fixed widths of the port fields.
   localparam int SLOT_FIELD_W = 3;
   localparam int TIME_FIELD_W = 16;
   localparam int LAX_FIELD_W  = 18;
   localparam int MISS_W       = 16;

   // Request action codes.
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   // Scan record that walks the cell row, one cell per cycle.
   typedef struct packed {
      logic                    token;
      logic                    found;
      logic [SLOT_W-1:0]       slot;
      logic signed [LAX_W-1:0] lax;
      logic [TIME_BITS-1:0]    rem;
   } llf_scan_type;

   // Slot write, broadcast to every cell.
   typedef struct packed {
      logic                 en;
      logic [SLOT_W-1:0]    slot;
      logic [TIME_BITS-1:0] arrival;
      logic [TIME_BITS-1:0] burst;
      logic [TIME_BITS-1:0] deadline;
   } llf_load_type;

   // Remaining-work decrement of the chosen slot.
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
   } llf_dec_type;

endpackage

>>> design/llf_cell.sv
// ---------------------------------------------------------------------------
// Scheduler cell
// Holds one task slot and folds it into the passing scan record.
// ---------------------------------------------------------------------------
module llf_cell
   import llf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [SLOT_W-1:0]    cell_id,
   input  logic [TIME_BITS-1:0] now,
   input  llf_load_type         load,
   input  llf_dec_type          dec,
   input  llf_scan_type         scan_in,
   output llf_scan_type         scan_out,
   output logic                 busy
);

   logic [TIME_BITS-1:0]    arrival_ff;
   logic [TIME_BITS-1:0]    deadline_ff;
   logic [TIME_BITS-1:0]    remaining_ff;
   llf_scan_type            scan_ff;
   llf_scan_type            scan_in_next;
   logic                    ready;
   logic signed [LAX_W-1:0] lax;
   logic                    take;

   // A slot competes once it has arrived and still has work.
   assign ready = (remaining_ff != '0) && (arrival_ff <= now);
   assign lax   = $signed({2'b00, deadline_ff}) - $signed({2'b00, now})
                - $signed({2'b00, remaining_ff});

   // Strictly less wins, so the lower slot seen earlier keeps a tie.
   assign take = scan_in.token && ready && (!scan_in.found || (lax < scan_in.lax));

   always_comb begin
      scan_in_next = scan_in;
      if (take) begin
         scan_in_next.found = 1'b1;
         scan_in_next.slot  = cell_id;
         scan_in_next.lax   = lax;
         scan_in_next.rem   = remaining_ff;
      end
   end

   // Hand the record to the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else begin
         scan_ff <= scan_in_next;
      end
   end

   // Slot storage: loads and decrements never coincide.
   always_ff @(posedge clock) begin
      if (reset) begin
         arrival_ff   <= '0;
         deadline_ff  <= '0;
         remaining_ff <= '0;
      end else if (load.en && (load.slot == cell_id)) begin
         arrival_ff   <= load.arrival;
         deadline_ff  <= load.deadline;
         remaining_ff <= load.burst;
      end else if (dec.en && (dec.slot == cell_id)) begin
         remaining_ff <= remaining_ff - 1'b1;
      end
   end

   assign scan_out = scan_ff;
   assign busy     = (remaining_ff != '0);

endmodule

>>> design/least_laxity_first_scheduler_top.sv
// Responses: a load request gives no response; a tick request raises its response once its
// scan record has left the last slot cell and the summary state has registered the result.
// Flow: loads are taken one per cycle while the block is idle; a tick holds the block until
// its response is taken, the scan record walking the row of slot cells one cell per cycle.
// Reset: synchronous, active high; clears all slots, the time and the miss count.
// ---------------------------------------------------------------------------
// Least-laxity-first scheduler top level
// Control, time and miss counters around a row of slot cells.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module least_laxity_first_scheduler_top
   import llf_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_action,
   input  logic [SLOT_FIELD_W-1:0]        req_slot,
   input  logic [TIME_FIELD_W-1:0]        req_arrival,
   input  logic [TIME_FIELD_W-1:0]        req_burst,
   input  logic [TIME_FIELD_W-1:0]        req_deadline,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_idle,
   output logic [SLOT_FIELD_W-1:0]        rsp_chosen_slot,
   output logic signed [LAX_FIELD_W-1:0]  rsp_chosen_laxity,
   output logic [TIME_FIELD_W-1:0]        rsp_remaining_after,
   output logic                           rsp_will_miss,
   output logic                           rsp_finished,
   output logic [TIME_FIELD_W-1:0]        rsp_finish_time,
   output logic                           rsp_all_done,
   output logic [MISS_W-1:0]              rsp_miss_total
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_SUM  = 4'b0100,
      S_OUT  = 4'b1000
   } llf_state_type;

   llf_state_type           state_ff, state_in;
   logic [TIME_BITS-1:0]    now_ff;
   logic [MISS_W-1:0]       miss_ff;
   logic                    found_ff;
   logic [SLOT_W-1:0]       slot_ff;
   logic signed [LAX_W-1:0] lax_ff;
   logic [TIME_BITS-1:0]    rem_ff;

   logic                    rsp_valid_ff;
   logic                    idle_ff;
   logic [SLOT_FIELD_W-1:0] chosen_slot_ff;
   logic [LAX_FIELD_W-1:0]  chosen_lax_ff;
   logic [TIME_FIELD_W-1:0] rem_after_ff;
   logic                    will_miss_ff;
   logic                    finished_ff;
   logic [TIME_FIELD_W-1:0] finish_time_ff;
   logic                    all_done_ff;

   llf_scan_type            scan_head;
   llf_scan_type            chain [MAX_TASKS+1];
   llf_load_type            load;
   llf_dec_type             dec;
   logic [MAX_TASKS-1:0]    busy;
   logic                    accept;
   logic                    scan_end;
   logic                    miss_now;
   logic                    fin_now;
   logic [TIME_BITS-1:0]    now_in;
   logic [MISS_W-1:0]       miss_in;

   // Requests are taken only while the block is idle.
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // Load broadcast; slots beyond the table are ignored.
   always_comb begin
      load.en       = accept && (req_action == ACT_LOAD) && (32'(req_slot) < MAX_TASKS);
      load.slot     = SLOT_W'(req_slot);
      load.arrival  = TIME_BITS'(req_arrival);
      load.burst    = TIME_BITS'(req_burst);
      load.deadline = TIME_BITS'(req_deadline);
   end

   // A tick request launches an empty scan record into the first cell.
   always_comb begin
      scan_head       = '0;
      scan_head.token = accept && (req_action == ACT_TICK);
   end

   assign chain[0] = scan_head;

   assign scan_end = (state_ff == S_SCAN) && chain[MAX_TASKS].token;

   // The winner loses one unit of work as the record leaves the row.
   assign dec.en   = scan_end && chain[MAX_TASKS].found;
   assign dec.slot = chain[MAX_TASKS].slot;

   // Row of slot cells.
   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      llf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_id  (SLOT_W'(i)),
         .now      (now_ff),
         .load     (load),
         .dec      (dec),
         .scan_in  (chain[i]),
         .scan_out (chain[i+1]),
         .busy     (busy[i])
      );
   end

   // Control sequence: idle, scan, summarize, present.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_action == ACT_TICK)) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (scan_end) state_in = S_SUM;
         end
         S_SUM: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture the winner as the record leaves the last cell.
   always_ff @(posedge clock) begin
      if (scan_end) begin
         found_ff <= chain[MAX_TASKS].found;
         slot_ff  <= chain[MAX_TASKS].slot;
         lax_ff   <= chain[MAX_TASKS].lax;
         rem_ff   <= chain[MAX_TASKS].rem;
      end
   end

   // Summary terms of the tick.
   assign miss_now = found_ff && lax_ff[LAX_W-1];
   assign fin_now  = found_ff && (rem_ff == TIME_BITS'(1));
   assign now_in   = (now_ff != '1) ? now_ff + 1'b1 : now_ff;
   assign miss_in  = (miss_now && (miss_ff != '1)) ? miss_ff + 1'b1 : miss_ff;

   // Time advances once per tick and the miss count once per missing tick, both saturating.
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff  <= '0;
         miss_ff <= '0;
      end else if (state_ff == S_SUM) begin
         now_ff  <= now_in;
         miss_ff <= miss_in;
      end
   end

   // Response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_SUM) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload; idle ticks report zeros for the task fields.
   always_ff @(posedge clock) begin
      if (state_ff == S_SUM) begin
         idle_ff        <= !found_ff;
         chosen_slot_ff <= found_ff ? SLOT_FIELD_W'(slot_ff) : '0;
         chosen_lax_ff  <= found_ff ? LAX_FIELD_W'(lax_ff) : '0;
         rem_after_ff   <= found_ff ? TIME_FIELD_W'(rem_ff - 1'b1) : '0;
         will_miss_ff   <= miss_now;
         finished_ff    <= fin_now;
         finish_time_ff <= fin_now ? TIME_FIELD_W'(now_in) : '0;
         all_done_ff    <= ~|busy;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_idle            = idle_ff;
   assign rsp_chosen_slot     = chosen_slot_ff;
   assign rsp_chosen_laxity   = chosen_lax_ff;
   assign rsp_remaining_after = rem_after_ff;
   assign rsp_will_miss       = will_miss_ff;
   assign rsp_finished        = finished_ff;
   assign rsp_finish_time     = finish_time_ff;
   assign rsp_all_done        = all_done_ff;
   assign rsp_miss_total      = miss_ff;

   // Checks on the scan sequence and response consistency.
   `ASSERT_NEXT(a_scan_to_sum, clock, reset, scan_end, state_ff == S_SUM)
   `ASSERT_NEXT(a_sum_to_rsp, clock, reset, state_ff == S_SUM, rsp_valid)
   `ASSERT_IMPLY(a_idle_zero, clock, reset, rsp_valid && rsp_idle,
      (rsp_chosen_slot == '0) && (rsp_remaining_after == '0) && !rsp_finished)
   `ASSERT_IMPLY(a_miss_sign, clock, reset, rsp_valid,
      rsp_will_miss == rsp_chosen_laxity[LAX_FIELD_W-1])

endmodule

>>> dv/tb_top.sv
// ---------------------------------------------------------------------------
// Least-laxity-first scheduler testbench
// Loads tasks and issues ticks through the request channel, predicts every
// tick response with a cycle-free copy of the task table, and compares each
// accepted response field by field. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
   import llf_pkg::*;
;

   localparam logic [15:0] TIME_TOP    = 16'hFFFF;
   localparam logic [15:0] MISS_TOP    = 16'hFFFF;
   localparam int          CYCLE_LIMIT = 10_000_000;
   localparam int          DRAIN_WAIT  = 16;

   // One expected tick response.
   typedef struct packed {
      logic        idle;
      logic [2:0]  slot;
      logic [17:0] laxity;
      logic [15:0] remaining;
      logic        will_miss;
      logic        finished;
      logic [15:0] finish_time;
      logic        all_done;
      logic [15:0] miss_total;
   } sched_pick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid    = 1'b0;
   logic                          req_stall;
   logic                          req_action   = ACT_LOAD;
   logic [SLOT_FIELD_W-1:0]       req_slot     = '0;
   logic [TIME_FIELD_W-1:0]       req_arrival  = '0;
   logic [TIME_FIELD_W-1:0]       req_burst    = '0;
   logic [TIME_FIELD_W-1:0]       req_deadline = '0;
   logic                          rsp_valid;
   logic                          rsp_stall    = 1'b1;
   logic                          rsp_idle;
   logic [SLOT_FIELD_W-1:0]       rsp_chosen_slot;
   logic signed [LAX_FIELD_W-1:0] rsp_chosen_laxity;
   logic [TIME_FIELD_W-1:0]       rsp_remaining_after;
   logic                          rsp_will_miss;
   logic                          rsp_finished;
   logic [TIME_FIELD_W-1:0]       rsp_finish_time;
   logic                          rsp_all_done;
   logic [MISS_W-1:0]             rsp_miss_total;

   // Shadow task table and counters of the scheduler.
   logic [15:0] task_arr [MAX_TASKS];
   logic [15:0] task_ddl [MAX_TASKS];
   logic [15:0] task_rem [MAX_TASKS];
   logic [15:0] now_tick;
   logic [15:0] miss_cnt;

   sched_pick_type pending_picks [$];
   int             fail_count    = 0;
   int             cycle_count   = 0;
   int             req_max_gap   = 10;
   int             rsp_max_stall = 10;

   least_laxity_first_scheduler_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_slot            (req_slot),
      .req_arrival         (req_arrival),
      .req_burst           (req_burst),
      .req_deadline        (req_deadline),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_idle            (rsp_idle),
      .rsp_chosen_slot     (rsp_chosen_slot),
      .rsp_chosen_laxity   (rsp_chosen_laxity),
      .rsp_remaining_after (rsp_remaining_after),
      .rsp_will_miss       (rsp_will_miss),
      .rsp_finished        (rsp_finished),
      .rsp_finish_time     (rsp_finish_time),
      .rsp_all_done        (rsp_all_done),
      .rsp_miss_total      (rsp_miss_total)
   );

   // Clock with a 2 ns period.
   initial begin
      forever #1 clock = ~clock;
   end

   // Run-length guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Write one slot of the shadow table.
   function automatic void store_task(input logic [2:0] slot, input logic [15:0] arr,
                                      input logic [15:0] burst, input logic [15:0] ddl);
      task_arr[slot] = arr;
      task_rem[slot] = burst;
      task_ddl[slot] = ddl;
   endfunction

   // Pick the ready task with the least laxity, run it for one tick and
   // return what the scheduler should report.
   function automatic sched_pick_type advance_schedule();
      sched_pick_type pick;
      int best;
      int best_lax;
      int lax;
      int ddl;
      int now;
      int rem;
      best     = -1;
      best_lax = 0;
      pick     = '0;
      now      = now_tick;
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (task_rem[i] != 0 && task_arr[i] <= now_tick) begin
            ddl = task_ddl[i];
            rem = task_rem[i];
            lax = ddl - now - rem;
            if (best < 0 || lax < best_lax) begin
               best     = i;
               best_lax = lax;
            end
         end
      end
      if (best < 0) begin
         pick.idle = 1'b1;
      end else begin
         pick.slot   = best[2:0];
         pick.laxity = best_lax[17:0];
         if (best_lax < 0) begin
            pick.will_miss = 1'b1;
            if (miss_cnt != MISS_TOP) miss_cnt++;
         end
         task_rem[best]--;
         pick.remaining = task_rem[best];
         if (task_rem[best] == 0) begin
            pick.finished    = 1'b1;
            pick.finish_time = (now_tick != TIME_TOP) ? now_tick + 16'd1 : TIME_TOP;
         end
      end
      pick.all_done = 1'b1;
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (task_rem[i] != 0) pick.all_done = 1'b0;
      end
      if (now_tick != TIME_TOP) now_tick++;
      pick.miss_total = miss_cnt;
      return pick;
   endfunction

   // Present one request after a random gap, wait for it to be taken and
   // update the shadow table.
   task automatic send_request(input logic act, input logic [2:0] slot,
                               input logic [15:0] arr, input logic [15:0] burst,
                               input logic [15:0] ddl);
      int gap;
      gap = $urandom_range(0, req_max_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_slot     <= slot;
      req_arrival  <= arr;
      req_burst    <= burst;
      req_deadline <= ddl;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (act == ACT_LOAD) begin
         store_task(slot, arr, burst, ddl);
      end else begin
         pending_picks.insert(pending_picks.size(), advance_schedule());
      end
   endtask

   task automatic send_tick();
      send_request(ACT_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic check_field(input string name, input logic [17:0] exp_val,
                              input logic [17:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t ERROR rsp %s: expected %0h, actual %0h", $time, name, exp_val,
                  act_val);
         fail_count++;
      end
   endtask

   // Response side: stall a random number of cycles on each response, then
   // take it and compare it with the oldest expectation.
   initial begin : rsp_side
      int             hold;
      sched_pick_type exp_pick;
      wait (reset === 1'b0);
      forever begin
         hold = $urandom_range(0, rsp_max_stall);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            do @(posedge clock); while (rsp_valid !== 1'b1);
            repeat (hold - 1) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (pending_picks.size() == 0) begin
            $display("%0t ERROR response with no tick outstanding", $time);
            fail_count++;
         end else begin
            exp_pick = pending_picks.pop_front();
            check_field("idle", exp_pick.idle, rsp_idle);
            check_field("chosen_slot", exp_pick.slot, rsp_chosen_slot);
            check_field("chosen_laxity", exp_pick.laxity, rsp_chosen_laxity);
            check_field("remaining_after", exp_pick.remaining, rsp_remaining_after);
            check_field("will_miss", exp_pick.will_miss, rsp_will_miss);
            check_field("finished", exp_pick.finished, rsp_finished);
            check_field("finish_time", exp_pick.finish_time, rsp_finish_time);
            check_field("all_done", exp_pick.all_done, rsp_all_done);
            check_field("miss_total", exp_pick.miss_total, rsp_miss_total);
         end
      end
   end

   // Ticks on an empty table are idle and report all work done.
   task automatic test_empty_table();
      send_tick();
      send_tick();
   endtask

   // Ties, future arrivals, empty slots, negative laxity and completion.
   task automatic test_directed_picks();
      send_request(ACT_LOAD, 3'd7, 16'd0, 16'd2, 16'hFFFF);
      send_request(ACT_LOAD, 3'd3, 16'd0, 16'd2, 16'hFFFF);
      send_request(ACT_LOAD, 3'd5, 16'hFFFF, 16'hFFFF, 16'd0);
      send_request(ACT_LOAD, 3'd0, 16'd0, 16'd0, 16'd100);
      repeat (4) send_tick();
      // Deadline already behind: every pick of this task is a predicted miss.
      send_request(ACT_LOAD, 3'd1, 16'd0, 16'd3, 16'd0);
      send_tick();
      send_request(ACT_LOAD, 3'd2, 16'd0, 16'd1, 16'hFFFF);
      repeat (3) send_tick();
      // Clear the far-future task, so the table drains completely.
      send_request(ACT_LOAD, 3'd5, 16'd0, 16'd0, 16'd0);
      send_tick();
      send_request(ACT_LOAD, 3'd4, 16'hFFFF, 16'd1, 16'hFFFF);
      send_tick();
      send_request(ACT_LOAD, 3'd4, 16'd0, 16'd0, 16'd0);
      // A task becomes ready exactly when its arrival equals the current time.
      send_request(ACT_LOAD, 3'd6, now_tick + 16'd1, 16'd1, 16'hFFFF);
      send_tick();
      send_tick();
   endtask

   // Mostly well-formed task sets near the current time, some noise.
   task automatic test_random_mix(input int count);
      logic [2:0]  slot;
      logic [15:0] arr;
      logic [15:0] burst;
      logic [15:0] ddl;
      int          mode;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 45) begin
            send_tick();
         end else begin
            slot = 3'($urandom_range(0, 7));
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
               arr   = 16'($urandom);
               burst = 16'($urandom);
               ddl   = 16'($urandom);
            end else begin
               arr   = now_tick + 16'($urandom_range(0, 6));
               burst = (mode == 1) ? 16'd0 : 16'($urandom_range(1, 6));
               ddl   = now_tick + 16'($urandom_range(0, 40));
            end
            send_request(ACT_LOAD, slot, arr, burst, ddl);
         end
      end
   endtask

   // Back-to-back missing ticks until both the time and the miss count
   // saturate, then a few more ticks at the top.
   task automatic test_time_saturation();
      int extra;
      req_max_gap   = 0;
      rsp_max_stall = 0;
      for (int s = 1; s < MAX_TASKS; s++) begin
         send_request(ACT_LOAD, 3'(s), 16'd0, 16'd0, 16'd0);
      end
      // A long overdue task in slot zero misses on every tick.
      send_request(ACT_LOAD, 3'd0, 16'd0, 16'hFFFF, 16'd0);
      extra = 0;
      while (extra < 4) begin
         if (task_rem[0] == 0) send_request(ACT_LOAD, 3'd0, 16'd0, 16'hFFFF, 16'd0);
         send_tick();
         if (now_tick == TIME_TOP && miss_cnt == MISS_TOP) extra++;
      end
      req_max_gap   = 10;
      rsp_max_stall = 10;
   endtask

   // Completion at the top of time reports a saturated finish time.
   task automatic test_finish_at_top();
      send_request(ACT_LOAD, 3'd0, 16'd0, 16'd0, 16'd0);
      send_request(ACT_LOAD, 3'd1, 16'hFFFF, 16'd1, 16'hFFFF);
      send_request(ACT_LOAD, 3'd2, 16'd0, 16'd2, 16'hFFFF);
      repeat (4) send_tick();
   endtask

   // Test sequence.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      now_tick = '0;
      miss_cnt = '0;
      for (int i = 0; i < MAX_TASKS; i++) store_task(3'(i), '0, '0, '0);

      test_empty_table();
      test_directed_picks();
      test_random_mix(1500);
      test_time_saturation();
      test_finish_at_top();

      req_valid <= 1'b0;
      while (pending_picks.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/llf_pkg.sv
design/llf_cell.sv
design/least_laxity_first_scheduler_top.sv
dv/tb_top.sv
